/* src/sps_pkg.sv */
package sps_pkg;

    // Largest limit that the mark store can hold.
    localparam int MAX_N = 4096;

    // Field widths fixed by the interface.
    localparam int LIMIT_W = 13;
    localparam int SUM_W   = 24;

    // Mark store geometry: entries 0..MAX_N.
    localparam int DEPTH  = MAX_N + 1;
    localparam int ADDR_W = $clog2(MAX_N + 1);

    // Index and multiple counters reach at most 2*MAX_N.
    localparam int IDX_W = $clog2(2 * MAX_N + 1);

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FILL,
        OP_RESTART,
        OP_READ,
        OP_START_CLR,
        OP_CLEAR,
        OP_NEXT,
        OP_OUT
    } dp_op_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_lt_two;
        logic i_gt_n;
        logic j_gt_n;
        logic mark;
    } dp_status_t;

endpackage

/* src/sps_datapath.sv */
module sps_datapath (
    input  logic                        clk,
    input  logic [sps_pkg::LIMIT_W-1:0] limit,
    input  sps_pkg::dp_op_t             op,
    output sps_pkg::dp_status_t         status,
    output logic [sps_pkg::SUM_W-1:0]   prime_sum
);

    logic                        mark_store [0:sps_pkg::DEPTH-1];
    logic [sps_pkg::IDX_W-1:0]   n_reg;
    logic [sps_pkg::IDX_W-1:0]   i_reg;
    logic [sps_pkg::IDX_W-1:0]   j_reg;
    logic [sps_pkg::SUM_W-1:0]   sum_reg;
    logic [sps_pkg::SUM_W-1:0]   out_reg;
    logic                        mark_reg;
    logic [sps_pkg::IDX_W-1:0]   limit_sat;

    // Requests above the store size saturate to it.
    always_comb
    begin
        if (32'(limit) > sps_pkg::MAX_N)
        begin
            limit_sat = sps_pkg::IDX_W'(sps_pkg::MAX_N);
        end
        else
        begin
            limit_sat = sps_pkg::IDX_W'(limit);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            sps_pkg::OP_LOAD:
            begin
                n_reg   <= limit_sat;
                i_reg   <= sps_pkg::IDX_W'(2);
                sum_reg <= '0;
            end
            sps_pkg::OP_FILL:
            begin
                mark_store[i_reg[sps_pkg::ADDR_W-1:0]] <= 1'b1;
                i_reg <= i_reg + sps_pkg::IDX_W'(1);
            end
            sps_pkg::OP_RESTART:
            begin
                i_reg <= sps_pkg::IDX_W'(2);
            end
            sps_pkg::OP_READ:
            begin
                mark_reg <= mark_store[i_reg[sps_pkg::ADDR_W-1:0]];
            end
            sps_pkg::OP_START_CLR:
            begin
                j_reg   <= {i_reg[sps_pkg::IDX_W-2:0], 1'b0};
                sum_reg <= sum_reg + sps_pkg::SUM_W'(i_reg);
            end
            sps_pkg::OP_CLEAR:
            begin
                mark_store[j_reg[sps_pkg::ADDR_W-1:0]] <= 1'b0;
                j_reg <= j_reg + i_reg;
            end
            sps_pkg::OP_NEXT:
            begin
                i_reg <= i_reg + sps_pkg::IDX_W'(1);
            end
            sps_pkg::OP_OUT:
            begin
                out_reg <= sum_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.n_lt_two = (n_reg < sps_pkg::IDX_W'(2));
    assign status.i_gt_n   = (i_reg > n_reg);
    assign status.j_gt_n   = (j_reg > n_reg);
    assign status.mark     = mark_reg;
    assign prime_sum       = out_reg;

endmodule

/* src/sps_controller.sv */
module sps_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  sps_pkg::dp_status_t status,
    output sps_pkg::dp_op_t     op
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FILL,
        S_READ,
        S_TEST,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        op         = sps_pkg::OP_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = sps_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.n_lt_two ? S_DONE : S_FILL;
            end
            S_FILL:
            begin
                if (status.i_gt_n)
                begin
                    op         = sps_pkg::OP_RESTART;
                    state_next = S_READ;
                end
                else
                begin
                    op = sps_pkg::OP_FILL;
                end
            end
            S_READ:
            begin
                if (status.i_gt_n)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op         = sps_pkg::OP_READ;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (status.mark)
                begin
                    op         = sps_pkg::OP_START_CLR;
                    state_next = S_CLEAR;
                end
                else
                begin
                    op         = sps_pkg::OP_NEXT;
                    state_next = S_READ;
                end
            end
            S_CLEAR:
            begin
                if (status.j_gt_n)
                begin
                    op         = sps_pkg::OP_NEXT;
                    state_next = S_READ;
                end
                else
                begin
                    op = sps_pkg::OP_CLEAR;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    op         = sps_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (op == sps_pkg::OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* src/sieve_prime_sum_core.sv */
// Sums every prime from 2 up to the limit of each input transfer, using a sieve of
// Eratosthenes over a one-bit mark store of MAX_N+1 entries; limits above MAX_N saturate
// to MAX_N, and a limit of 0 or 1 gives 0. One item is worked on at a time: the input
// stalls from the transfer until the result is handed to the output register, which
// holds it until the downstream side takes it. For a saturated limit n of at least 2,
// an item marks the candidates 2..n, then reads and tests the mark of each index, and
// clears each multiple of each prime that it finds.
module sieve_prime_sum_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sps_pkg::LIMIT_W-1:0] limit,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sps_pkg::SUM_W-1:0]   prime_sum
);

    // Command and status between the sequencer and the datapath.
    sps_pkg::dp_op_t     op;
    sps_pkg::dp_status_t status;

    // The controller walks the fill, sieve and output phases, and owns the
    // handshakes of both channels.
    sps_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .op        (op)
    );

    // The datapath holds the mark store, the index and multiple counters, the
    // running sum and the output register. A prime is added to the sum when
    // its mark is tested and found set, since no later step can clear it.
    sps_datapath u_dp (
        .clk       (clk),
        .limit     (limit),
        .op        (op),
        .status    (status),
        .prime_sum (prime_sum)
    );

endmodule

/* src/sps_checker.sv */
module sps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [sps_pkg::SUM_W-1:0]   prime_sum
);

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(prime_sum))
        else $error("result changed while stalled");

    // After a transfer in, the block is busy with that item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after transfer");

    // A new result only appears while an item is being worked on.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in progress");

    // No result can be ready in the cycle right after a transfer in.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind sieve_prime_sum_core sps_checker u_sps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .prime_sum (prime_sum)
);
